/* rtl/m3i_pkg.sv */
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Matrix dimension and number of matrix elements
	localparam int MAT_DIM = 3;
	localparam int MAT_N   = 9;

endpackage

/* rtl/m3i_cross.sv */
// ----------------------------------------------------------------------------
// m3i_cross
// Stages 1-2: column pair cross products P0 = c1 x c2, P1 = c2 x c0,
// P2 = c0 x c1, exact, plus column 0 carried along for the determinant.
// ----------------------------------------------------------------------------
module m3i_cross import m3i_pkg::*; #(
	parameter int W = ELEM_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic signed [W-1:0]   m [MAT_N],
	output logic                  out_v,
	output logic signed [2*W:0]   p [MAT_DIM][MAT_DIM],
	output logic signed [W-1:0]   c0 [MAT_DIM]
);

	logic signed [2*W-1:0] pa_s1 [MAT_DIM][MAT_DIM];
	logic signed [2*W-1:0] pb_s1 [MAT_DIM][MAT_DIM];
	logic signed [2*W:0]   p_s2  [MAT_DIM][MAT_DIM];
	logic signed [W-1:0]   c0_s1 [MAT_DIM];
	logic signed [W-1:0]   c0_s2 [MAT_DIM];
	logic                  v_s1, v_s2;

	for (genvar y = 0; y < MAT_DIM; y++) begin : g_y
		for (genvar i = 0; i < MAT_DIM; i++) begin : g_i
			localparam int A  = (y + 1) % MAT_DIM;
			localparam int B  = (y + 2) % MAT_DIM;
			localparam int I1 = (i + 1) % MAT_DIM;
			localparam int I2 = (i + 2) % MAT_DIM;

			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[y][i] <= m[MAT_DIM*A + I1] * m[MAT_DIM*B + I2];
					pb_s1[y][i] <= m[MAT_DIM*A + I2] * m[MAT_DIM*B + I1];
					p_s2[y][i]  <= (2*W+1)'(pa_s1[y][i]) - (2*W+1)'(pb_s1[y][i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAT_DIM; i++) begin
				c0_s1[i] <= m[i];
				c0_s2[i] <= c0_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	assign out_v = v_s2;
	assign p     = p_s2;
	assign c0    = c0_s2;

endmodule

/* rtl/m3i_det.sv */
// ----------------------------------------------------------------------------
// m3i_det
// Stages 3-5: determinant c0 . P0. Each 32x65 product is split into a low
// unsigned and a high signed partial product, recombined, then summed.
// ----------------------------------------------------------------------------
module m3i_det import m3i_pkg::*; #(
	parameter int W = ELEM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_v,
	input  logic signed [2*W:0]    p_in [MAT_DIM][MAT_DIM],
	input  logic signed [W-1:0]    c0 [MAT_DIM],
	output logic                   out_v,
	output logic signed [2*W:0]    p [MAT_DIM][MAT_DIM],
	output logic signed [3*W+2:0]  det
);

	localparam int DW = 3*W + 3;

	logic signed [2*W:0]  lo_s3 [MAT_DIM];
	logic signed [2*W:0]  hi_s3 [MAT_DIM];
	logic signed [DW-1:0] t_s4  [MAT_DIM];
	logic signed [DW-1:0] det_s5;
	logic signed [2*W:0]  p_s3 [MAT_DIM][MAT_DIM];
	logic signed [2*W:0]  p_s4 [MAT_DIM][MAT_DIM];
	logic signed [2*W:0]  p_s5 [MAT_DIM][MAT_DIM];
	logic                 v_s3, v_s4, v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAT_DIM; i++) begin
				lo_s3[i] <= c0[i] * $signed({1'b0, p_in[0][i][W-1:0]});
				hi_s3[i] <= c0[i] * $signed(p_in[0][i][2*W:W]);
				t_s4[i]  <= (DW'(hi_s3[i]) <<< W) + DW'(lo_s3[i]);
			end
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			p_s3   <= p_in;
			p_s4   <= p_s3;
			p_s5   <= p_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign out_v = v_s5;
	assign p     = p_s5;
	assign det   = det_s5;

endmodule

/* rtl/m3i_div.sv */
// ----------------------------------------------------------------------------
// m3i_div
// One divider lane: restoring division, one quotient bit per stage, then a
// round/saturate stage. Numerator is 2x the magnitude so the extra quotient
// bit gives round half away from zero; the top bit flags overflow.
// ----------------------------------------------------------------------------
module m3i_div import m3i_pkg::*; #(
	parameter int W  = ELEM_WIDTH_DEF,
	parameter int NW = 4*W + 2,
	parameter int DW = 3*W + 3
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg,
	output logic [W-1:0]  res
);

	localparam int S  = W + 2;
	localparam int RW = (NW > DW + S) ? NW : DW + S;

	logic [RW-1:0] rem_s [S];
	logic [S-1:0]  q_s   [S];
	logic [DW-1:0] den_s [S];
	logic          neg_s [S];
	logic [W-1:0]  res_q;

	for (genvar g = 0; g < S; g++) begin : g_st
		localparam int K = S - 1 - g;
		logic [RW-1:0] rprev, dsh;
		logic [S-1:0]  qprev;
		logic [DW-1:0] dprev;
		logic          nprev, ge;

		if (g == 0) begin : g_first
			assign rprev = RW'(num);
			assign qprev = '0;
			assign dprev = den;
			assign nprev = neg;
		end else begin : g_next
			assign rprev = rem_s[g-1];
			assign qprev = q_s[g-1];
			assign dprev = den_s[g-1];
			assign nprev = neg_s[g-1];
		end

		assign dsh = RW'(dprev) << K;
		assign ge  = (rprev >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? rprev - dsh : rprev;
				q_s[g]   <= qprev | (ge ? (S'(1) << K) : '0);
				den_s[g] <= dprev;
				neg_s[g] <= nprev;
			end
		end
	end

	logic         ovf, sgn;
	logic [W+1:0] q2p;
	logic [W:0]   qm;
	logic [W:0]   lim;
	logic [W-1:0] rnd;

	always_comb begin
		ovf = q_s[S-1][W+1];
		sgn = neg_s[S-1];
		q2p = {1'b0, q_s[S-1][W:0]} + (W+2)'(1);
		qm  = q2p[W+1:1];
		lim = (W+1)'(1) << (W-1);
		if (!sgn && (ovf || qm >= lim)) begin
			rnd = {1'b0, {(W-1){1'b1}}};
		end else if (sgn && (ovf || qm > lim)) begin
			rnd = {1'b1, {(W-1){1'b0}}};
		end else if (sgn) begin
			rnd = -qm[W-1:0];
		end else begin
			rnd = qm[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= rnd;
		end
	end

	assign res = res_q;

endmodule

/* rtl/matrix3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 Q-format matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  source    in         src_valid/src_stall  m0..m8
//  result    out        res_valid/res_stall  r0..r8, det_value, singular
//
//  One item per cycle while the result is not stalled. The pipeline has
//  5 stages of cross products and determinant, one operand prep stage,
//  ELEM_WIDTH + 2 divider stages (one quotient bit each) and a rounding stage.
//  A stalled result freezes the whole pipeline; src_stall is res_stall gated by res_valid.
//  Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module matrix3_inverse import m3i_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         src_valid,
	output logic                         src_stall,
	input  logic signed [ELEM_WIDTH-1:0] m0,
	input  logic signed [ELEM_WIDTH-1:0] m1,
	input  logic signed [ELEM_WIDTH-1:0] m2,
	input  logic signed [ELEM_WIDTH-1:0] m3,
	input  logic signed [ELEM_WIDTH-1:0] m4,
	input  logic signed [ELEM_WIDTH-1:0] m5,
	input  logic signed [ELEM_WIDTH-1:0] m6,
	input  logic signed [ELEM_WIDTH-1:0] m7,
	input  logic signed [ELEM_WIDTH-1:0] m8,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [ELEM_WIDTH-1:0] r0,
	output logic signed [ELEM_WIDTH-1:0] r1,
	output logic signed [ELEM_WIDTH-1:0] r2,
	output logic signed [ELEM_WIDTH-1:0] r3,
	output logic signed [ELEM_WIDTH-1:0] r4,
	output logic signed [ELEM_WIDTH-1:0] r5,
	output logic signed [ELEM_WIDTH-1:0] r6,
	output logic signed [ELEM_WIDTH-1:0] r7,
	output logic signed [ELEM_WIDTH-1:0] r8,
	output logic signed [ELEM_WIDTH-1:0] det_value,
	output logic                         singular
);

	localparam int W  = ELEM_WIDTH;
	localparam int PW = 2*W + 1;
	localparam int DW = 3*W + 3;
	localparam int NW = PW + 2*FRAC_BITS + 1;
	localparam int XW = DW + 2*FRAC_BITS;
	localparam int S  = W + 2;

	localparam logic signed [XW-1:0] HALF = XW'(1) << (2*FRAC_BITS - 1);
	localparam logic signed [XW-1:0] DMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] DMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

	logic en;
	logic signed [W-1:0]  m_in [MAT_N];
	logic                 v2, v5;
	logic signed [PW-1:0] p2 [MAT_DIM][MAT_DIM];
	logic signed [PW-1:0] p5 [MAT_DIM][MAT_DIM];
	logic signed [W-1:0]  c0 [MAT_DIM];
	logic signed [DW-1:0] det5;

	logic [NW-1:0]        num_s6 [MAT_N];
	logic                 neg_s6 [MAT_N];
	logic [DW-1:0]        den_s6;
	logic signed [XW-1:0] dr_s6;
	logic                 sing_s6, v_s6;

	logic [W-1:0]         q_res [MAT_N];
	logic [W-1:0]         ld_q [S+1];
	logic                 sl_q [S+1];
	logic                 vl_q [S+1];
	logic [W-1:0]         dsat;

	assign en        = !(res_valid && res_stall);
	assign src_stall = !en;

	assign m_in[0] = m0;
	assign m_in[1] = m1;
	assign m_in[2] = m2;
	assign m_in[3] = m3;
	assign m_in[4] = m4;
	assign m_in[5] = m5;
	assign m_in[6] = m6;
	assign m_in[7] = m7;
	assign m_in[8] = m8;

	m3i_cross #(.W(W)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (src_valid),
		.m      (m_in),
		.out_v  (v2),
		.p      (p2),
		.c0     (c0)
	);

	m3i_det #(.W(W)) u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v2),
		.p_in   (p2),
		.c0     (c0),
		.out_v  (v5),
		.p      (p5),
		.det    (det5)
	);

	// operand prep: magnitudes, quotient signs, determinant rounding
	for (genvar l = 0; l < MAT_N; l++) begin : g_lane
		localparam int X = l / MAT_DIM;
		localparam int Y = l % MAT_DIM;
		logic signed [PW-1:0] pv;
		logic [PW-1:0]        pabs;

		assign pv   = p5[Y][X];
		assign pabs = pv[PW-1] ? PW'(-pv) : PW'(pv);

		always_ff @(posedge clk) begin
			if (en) begin
				num_s6[l] <= {pabs, {(2*FRAC_BITS+1){1'b0}}};
				neg_s6[l] <= pv[PW-1] ^ det5[DW-1];
			end
		end

		m3i_div #(.W(W), .NW(NW), .DW(DW)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s6[l]),
			.den (den_s6),
			.neg (neg_s6[l]),
			.res (q_res[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= det5[DW-1] ? DW'(-det5) : DW'(det5);
			dr_s6   <= (XW'(det5) + (det5[DW-1] ? HALF - XW'(1) : HALF)) >>> (2*FRAC_BITS);
			sing_s6 <= (det5 == '0);
		end
	end

	always_comb begin
		if (dr_s6 > DMAX) begin
			dsat = DMAX[W-1:0];
		end else if (dr_s6 < DMIN) begin
			dsat = DMIN[W-1:0];
		end else begin
			dsat = dr_s6[W-1:0];
		end
	end

	// determinant and flags wait alongside the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			ld_q[0] <= sing_s6 ? '0 : dsat;
			sl_q[0] <= sing_s6;
			for (int i = 1; i <= S; i++) begin
				ld_q[i] <= ld_q[i-1];
				sl_q[i] <= sl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			for (int i = 0; i <= S; i++) begin
				vl_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s6    <= v5;
			vl_q[0] <= v_s6;
			for (int i = 1; i <= S; i++) begin
				vl_q[i] <= vl_q[i-1];
			end
		end
	end

	assign res_valid = vl_q[S];
	assign singular  = sl_q[S];
	assign det_value = ld_q[S];
	assign r0 = sl_q[S] ? '0 : q_res[0];
	assign r1 = sl_q[S] ? '0 : q_res[1];
	assign r2 = sl_q[S] ? '0 : q_res[2];
	assign r3 = sl_q[S] ? '0 : q_res[3];
	assign r4 = sl_q[S] ? '0 : q_res[4];
	assign r5 = sl_q[S] ? '0 : q_res[5];
	assign r6 = sl_q[S] ? '0 : q_res[6];
	assign r7 = sl_q[S] ? '0 : q_res[7];
	assign r8 = sl_q[S] ? '0 : q_res[8];

endmodule

/* rtl/m3i_chk.sv */
// ----------------------------------------------------------------------------
// m3i_chk
// Port-level checks for matrix3_inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_chk import m3i_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  src_valid,
	input logic                  src_stall,
	input logic                  res_valid,
	input logic                  res_stall,
	input logic [ELEM_WIDTH-1:0] r0,
	input logic [ELEM_WIDTH-1:0] r4,
	input logic [ELEM_WIDTH-1:0] r8,
	input logic [ELEM_WIDTH-1:0] det_value,
	input logic                  singular
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(r0) && $stable(det_value)
			&& $stable(singular))
		else $error("result item changed while stalled");

	a_src_blk: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> res_valid && res_stall)
		else $error("input stalled without a blocked result");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && singular |-> r0 == '0 && r4 == '0 && r8 == '0 && det_value == '0)
		else $error("singular item with nonzero fields");

	a_no_src: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !src_stall)
		else $error("input stalled with empty output");

endmodule

bind matrix3_inverse m3i_chk #(.ELEM_WIDTH(ELEM_WIDTH)) u_m3i_chk (.*);
